// File: src/cpgi_pkg.sv
// Shared types, widths and codes for the Coons patch grid interpolator.
// Used by every module of the block; depends on nothing.
package cpgi_pkg;

   // grid and number formats
   localparam int MAX_DIM    = 256;
   localparam int IDX_W      = 8;
   localparam int DIM_W      = 9;
   localparam int COORD_W    = 32;
   localparam int WGT_W      = 17;
   localparam int CPROD_W    = 2 * WGT_W;
   localparam int PROD_W     = WGT_W + 1 + COORD_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int Q_W        = 16;
   localparam int NUM_STAGES = 10;

   // register indexes of the configuration port
   localparam logic CSR_NUM_ROWS = 1'b0;
   localparam logic CSR_NUM_COLS = 1'b1;

   // what a query returns
   localparam logic [2:0] SEL_OUTSIDE  = 3'd0;
   localparam logic [2:0] SEL_TOP      = 3'd1;
   localparam logic [2:0] SEL_BOTTOM   = 3'd2;
   localparam logic [2:0] SEL_LEFT     = 3'd3;
   localparam logic [2:0] SEL_RIGHT    = 3'd4;
   localparam logic [2:0] SEL_INTERIOR = 3'd5;

   typedef logic [NUM_STAGES:1] stage_en_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   // edge and corner points read for one query
   typedef struct packed {
      point_type t_j;
      point_type b_j;
      point_type l_i;
      point_type r_i;
      point_type t_0;
      point_type t_n;
      point_type b_0;
      point_type b_n;
   } edge_pts_type;

   // edge weights and raw corner weight products, Q1.16 and Q2.32
   typedef struct packed {
      logic [WGT_W-1:0]   a0;
      logic [WGT_W-1:0]   a1;
      logic [WGT_W-1:0]   b0;
      logic [WGT_W-1:0]   b1;
      logic [CPROD_W-1:0] p00;
      logic [CPROD_W-1:0] p01;
      logic [CPROD_W-1:0] p10;
      logic [CPROD_W-1:0] p11;
   } weight_type;

endpackage

// File: src/cpgi_ram.sv
// One boundary store: MAX_DIM points, one write and one registered read port.
// Depends on cpgi_pkg.
module cpgi_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [cpgi_pkg::IDX_W-1:0] wr_addr,
   input  cpgi_pkg::point_type       wr_data,
   input  logic                      rd_en,
   input  logic [cpgi_pkg::IDX_W-1:0] rd_addr,
   output cpgi_pkg::point_type       rd_data
);
   import cpgi_pkg::*;

   point_type mem [MAX_DIM];
   point_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while the stage stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/cpgi_weight.sv
// Weight pipeline: long division of k/(d) over four stages, rounded edge
// weights, then the corner weight products. Depends on cpgi_pkg.
module cpgi_weight (
   input  logic                        clock,
   input  cpgi_pkg::stage_en_type      stage_en,
   input  logic [cpgi_pkg::IDX_W-1:0]  k_row,
   input  logic [cpgi_pkg::IDX_W-1:0]  d_row,
   input  logic [cpgi_pkg::IDX_W-1:0]  k_col,
   input  logic [cpgi_pkg::IDX_W-1:0]  d_col,
   output cpgi_pkg::weight_type        weights
);
   import cpgi_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] rem;
      logic [Q_W-1:0]   q;
      logic [IDX_W-1:0] d;
   } div_type;

   // four restoring steps, zeros shifted in
   function automatic div_type div4(div_type s);
      div_type        o;
      logic [IDX_W:0] r2;
      o = s;
      for (int t = 0; t < 4; t++) begin
         r2 = {o.rem, 1'b0};
         if (r2 >= {1'b0, o.d}) begin
            o.rem = IDX_W'(r2 - {1'b0, o.d});
            o.q   = {o.q[Q_W-2:0], 1'b1};
         end else begin
            o.rem = r2[IDX_W-1:0];
            o.q   = {o.q[Q_W-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   // rounded k/d and (d-k)/d from quotient and remainder, halves up
   function automatic logic [2*WGT_W-1:0] round_pair(div_type s);
      logic [IDX_W:0]   h;
      logic             up1;
      logic             up0;
      logic [IDX_W-1:0] rc;
      logic [WGT_W-1:0] qc;
      logic [WGT_W-1:0] w1;
      logic [WGT_W-1:0] w0;
      h   = {2'b00, s.d[IDX_W-1:1]};
      up1 = ({1'b0, s.rem} + h) >= {1'b0, s.d};
      rc  = (s.rem == '0) ? '0 : IDX_W'(s.d - s.rem);
      up0 = ({1'b0, rc} + h) >= {1'b0, s.d};
      qc  = WGT_W'(1 << Q_W) - {1'b0, s.q} - WGT_W'(s.rem != '0);
      w1  = {1'b0, s.q} + WGT_W'(up1);
      w0  = qc + WGT_W'(up0);
      return {w0, w1};
   endfunction

   div_type    row_ff [2:5];
   div_type    col_ff [2:5];
   div_type    row_in [2:5];
   div_type    col_in [2:5];
   weight_type edge_ff;
   weight_type edge_in;
   weight_type out_ff;
   weight_type out_in;

   // division steps
   always_comb begin
      row_in[2] = div4('{rem: k_row, q: '0, d: d_row});
      col_in[2] = div4('{rem: k_col, q: '0, d: d_col});
      for (int k = 3; k <= 5; k++) begin
         row_in[k] = div4(row_ff[k-1]);
         col_in[k] = div4(col_ff[k-1]);
      end
   end

   // rounded edge weights
   always_comb begin
      edge_in = '0;
      {edge_in.a0, edge_in.a1} = round_pair(row_ff[5]);
      {edge_in.b0, edge_in.b1} = round_pair(col_ff[5]);
   end

   // corner weight products
   always_comb begin
      out_in     = edge_ff;
      out_in.p00 = edge_ff.a0 * edge_ff.b0;
      out_in.p01 = edge_ff.a0 * edge_ff.b1;
      out_in.p10 = edge_ff.a1 * edge_ff.b0;
      out_in.p11 = edge_ff.a1 * edge_ff.b1;
   end

   always_ff @(posedge clock) begin
      for (int k = 2; k <= 5; k++) begin
         if (stage_en[k]) begin
            row_ff[k] <= row_in[k];
            col_ff[k] <= col_in[k];
         end
      end
      if (stage_en[6]) begin
         edge_ff <= edge_in;
      end
      if (stage_en[7]) begin
         out_ff <= out_in;
      end
   end

   assign weights = out_ff;

endmodule

// File: src/cpgi_blend.sv
// Blend pipeline: 24 weighted products, a registered partial sum, then the
// final sum rounded to Q16.16 and saturated. Depends on cpgi_pkg.
module cpgi_blend (
   input  logic                   clock,
   input  cpgi_pkg::stage_en_type stage_en,
   input  cpgi_pkg::weight_type   weights,
   input  cpgi_pkg::edge_pts_type pts,
   output cpgi_pkg::point_type    result
);
   import cpgi_pkg::*;

   function automatic logic signed [COORD_W-1:0] coord(point_type p, int c);
      logic signed [COORD_W-1:0] v;
      unique case (c)
         0:       v = p.x;
         1:       v = p.y;
         default: v = p.z;
      endcase
      return v;
   endfunction

   function automatic logic [WGT_W-1:0] round_corner(logic [CPROD_W-1:0] p);
      logic [CPROD_W-1:0] t;
      t = p + CPROD_W'(1 << (Q_W - 1));
      return t[Q_W+WGT_W-1:Q_W];
   endfunction

   function automatic logic signed [SUM_W-1:0] ext(logic signed [PROD_W-1:0] p);
      return {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
   endfunction

   logic signed [PROD_W-1:0] prod_ff [3][8];
   logic signed [PROD_W-1:0] prod_in [3][8];
   logic signed [SUM_W-1:0]  part_ff [3][4];
   logic signed [SUM_W-1:0]  part_in [3][4];
   logic [WGT_W-1:0]         wgt [8];
   point_type                pt [8];
   logic signed [SUM_W-1:0]  total;
   logic signed [SUM_W-1:0]  rnd;
   logic signed [SUM_W-Q_W-1:0] q;
   logic signed [COORD_W-1:0]   sat [3];

   // weighted products, corner terms still positive
   always_comb begin
      wgt[0] = weights.a0;  pt[0] = pts.t_j;
      wgt[1] = weights.a1;  pt[1] = pts.b_j;
      wgt[2] = weights.b0;  pt[2] = pts.l_i;
      wgt[3] = weights.b1;  pt[3] = pts.r_i;
      wgt[4] = round_corner(weights.p00);  pt[4] = pts.t_0;
      wgt[5] = round_corner(weights.p01);  pt[5] = pts.t_n;
      wgt[6] = round_corner(weights.p10);  pt[6] = pts.b_0;
      wgt[7] = round_corner(weights.p11);  pt[7] = pts.b_n;
      for (int c = 0; c < 3; c++) begin
         for (int t = 0; t < 8; t++) begin
            prod_in[c][t] = $signed({1'b0, wgt[t]}) * coord(pt[t], c);
         end
      end
   end

   // partial sums, corner terms subtracted
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         part_in[c][0] = ext(prod_ff[c][0]) + ext(prod_ff[c][1]);
         part_in[c][1] = ext(prod_ff[c][2]) + ext(prod_ff[c][3]);
         part_in[c][2] = -(ext(prod_ff[c][4]) + ext(prod_ff[c][5]));
         part_in[c][3] = -(ext(prod_ff[c][6]) + ext(prod_ff[c][7]));
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[9]) begin
         part_ff <= part_in;
      end
   end

   // final sum, round half up, saturate
   always_comb begin
      total = '0;
      rnd   = '0;
      q     = '0;
      for (int c = 0; c < 3; c++) begin
         total = part_ff[c][0] + part_ff[c][1] + part_ff[c][2] + part_ff[c][3];
         rnd   = total + SUM_W'(1 << (Q_W - 1));
         q     = rnd[SUM_W-1:Q_W];
         priority if (q > (SUM_W-Q_W)'((64'sd1 <<< (COORD_W - 1)) - 1)) begin
            sat[c] = {1'b0, {(COORD_W-1){1'b1}}};
         end else if (q < -(SUM_W-Q_W)'(64'sd1 <<< (COORD_W - 1))) begin
            sat[c] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            sat[c] = q[COORD_W-1:0];
         end
      end
   end

   assign result = '{z: sat[2], y: sat[1], x: sat[0]};

endmodule

// File: src/coons_patch_grid_interpolator_core.sv
// Bilinear Coons patch interpolator over the boundary of an M x N grid of
// Q16.16 points. Load requests store boundary points; query requests return the
// stored boundary point or the Coons blend of the four boundaries. The pipeline
// takes one request per cycle while the result side does not stall; a query's
// result is registered at the last stage and held there until it is taken. A
// stall on the result side holds each stage in place through a per-stage
// enable, so bubbles still fill. The boundary stores are memories with no
// clearing pass: an entry must be loaded before a query reads it.
// Depends on cpgi_pkg, cpgi_ram, cpgi_weight and cpgi_blend.
module coons_patch_grid_interpolator_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,   // row[7:0], col[15:8], x_in, y_in, z_in
   input  logic [0:0]    req_tuser,   // kind
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata,   // x_out, y_out, z_out
   output logic [0:0]    rsp_tuser,   // status
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [8:0]    csr_wr_data
);
   import cpgi_pkg::*;

   typedef struct packed {
      logic             is_query;
      logic [2:0]       sel;
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] j;
      logic [IDX_W-1:0] dm;
      logic [IDX_W-1:0] dn;
      logic             wr_top;
      logic             wr_bot;
      logic             wr_left;
      logic             wr_right;
      point_type        pt;
   } ctrl_type;

   logic [DIM_W-1:0] rows_ff;
   logic [DIM_W-1:0] cols_ff;
   logic [IDX_W-1:0] dm;
   logic [IDX_W-1:0] dn;

   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] valid_in;
   stage_en_type        stage_en;
   ctrl_type            ctl_ff [1:9];
   ctrl_type            ctl_in;
   edge_pts_type        ram_pts;
   edge_pts_type        pts_ff;
   point_type           bnd_ff [7:9];
   point_type           bnd_in;
   weight_type          weights;
   point_type           blend_pt;
   point_type           rsp_pt_ff;
   point_type           rsp_pt_in;
   logic                rsp_status_ff;
   logic                rsp_status_in;
   logic                wr_top;
   logic                wr_bot;
   logic                wr_left;
   logic                wr_right;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_W'(2);
         cols_ff <= DIM_W'(2);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_ROWS: rows_ff <= csr_wr_data;
            CSR_NUM_COLS: cols_ff <= csr_wr_data;
            default:      rows_ff <= rows_ff;
         endcase
      end
   end

   // clamped last line and last column index
   always_comb begin
      priority if (rows_ff < DIM_W'(2))  dm = IDX_W'(1);
      else if (rows_ff > DIM_W'(MAX_DIM)) dm = IDX_W'(MAX_DIM - 1);
      else                                dm = IDX_W'(rows_ff - DIM_W'(1));
      priority if (cols_ff < DIM_W'(2))  dn = IDX_W'(1);
      else if (cols_ff > DIM_W'(MAX_DIM)) dn = IDX_W'(MAX_DIM - 1);
      else                                dn = IDX_W'(cols_ff - DIM_W'(1));
   end

   // classify the incoming request
   always_comb begin
      logic in_grid;
      ctl_in          = '0;
      ctl_in.is_query = req_tuser[0];
      ctl_in.i        = req_tdata[7:0];
      ctl_in.j        = req_tdata[15:8];
      ctl_in.pt       = '{z: req_tdata[111:80], y: req_tdata[79:48], x: req_tdata[47:16]};
      ctl_in.dm       = dm;
      ctl_in.dn       = dn;
      in_grid         = (ctl_in.i <= dm) && (ctl_in.j <= dn);
      ctl_in.wr_top   = !ctl_in.is_query && in_grid && (ctl_in.i == '0);
      ctl_in.wr_bot   = !ctl_in.is_query && in_grid && (ctl_in.i == dm);
      ctl_in.wr_left  = !ctl_in.is_query && in_grid && (ctl_in.j == '0);
      ctl_in.wr_right = !ctl_in.is_query && in_grid && (ctl_in.j == dn);
      priority if (!in_grid)         ctl_in.sel = SEL_OUTSIDE;
      else if (ctl_in.i == '0)       ctl_in.sel = SEL_TOP;
      else if (ctl_in.i == dm)       ctl_in.sel = SEL_BOTTOM;
      else if (ctl_in.j == '0)       ctl_in.sel = SEL_LEFT;
      else if (ctl_in.j == dn)       ctl_in.sel = SEL_RIGHT;
      else                           ctl_in.sel = SEL_INTERIOR;
   end

   // per-stage enables: a stage loads when empty or when it drains
   always_comb begin
      stage_en[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_tready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   // valid bits; loads leave the pipeline once the stores are written
   always_comb begin
      valid_in[1] = req_tvalid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
      valid_in[6] = valid_ff[5] && ctl_ff[5].is_query;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // store writes at the same stage as the reads, keeping request order
   assign wr_top   = valid_ff[5] && stage_en[6] && ctl_ff[5].wr_top;
   assign wr_bot   = valid_ff[5] && stage_en[6] && ctl_ff[5].wr_bot;
   assign wr_left  = valid_ff[5] && stage_en[6] && ctl_ff[5].wr_left;
   assign wr_right = valid_ff[5] && stage_en[6] && ctl_ff[5].wr_right;

   cpgi_ram u_top_j (
      .clock(clock), .wr_en(wr_top), .wr_addr(ctl_ff[5].j), .wr_data(ctl_ff[5].pt),
      .rd_en(stage_en[6]), .rd_addr(ctl_ff[5].j), .rd_data(ram_pts.t_j)
   );
   cpgi_ram u_top_0 (
      .clock(clock), .wr_en(wr_top), .wr_addr(ctl_ff[5].j), .wr_data(ctl_ff[5].pt),
      .rd_en(stage_en[6]), .rd_addr('0), .rd_data(ram_pts.t_0)
   );
   cpgi_ram u_top_n (
      .clock(clock), .wr_en(wr_top), .wr_addr(ctl_ff[5].j), .wr_data(ctl_ff[5].pt),
      .rd_en(stage_en[6]), .rd_addr(ctl_ff[5].dn), .rd_data(ram_pts.t_n)
   );
   cpgi_ram u_bot_j (
      .clock(clock), .wr_en(wr_bot), .wr_addr(ctl_ff[5].j), .wr_data(ctl_ff[5].pt),
      .rd_en(stage_en[6]), .rd_addr(ctl_ff[5].j), .rd_data(ram_pts.b_j)
   );
   cpgi_ram u_bot_0 (
      .clock(clock), .wr_en(wr_bot), .wr_addr(ctl_ff[5].j), .wr_data(ctl_ff[5].pt),
      .rd_en(stage_en[6]), .rd_addr('0), .rd_data(ram_pts.b_0)
   );
   cpgi_ram u_bot_n (
      .clock(clock), .wr_en(wr_bot), .wr_addr(ctl_ff[5].j), .wr_data(ctl_ff[5].pt),
      .rd_en(stage_en[6]), .rd_addr(ctl_ff[5].dn), .rd_data(ram_pts.b_n)
   );
   cpgi_ram u_left (
      .clock(clock), .wr_en(wr_left), .wr_addr(ctl_ff[5].i), .wr_data(ctl_ff[5].pt),
      .rd_en(stage_en[6]), .rd_addr(ctl_ff[5].i), .rd_data(ram_pts.l_i)
   );
   cpgi_ram u_right (
      .clock(clock), .wr_en(wr_right), .wr_addr(ctl_ff[5].i), .wr_data(ctl_ff[5].pt),
      .rd_en(stage_en[6]), .rd_addr(ctl_ff[5].i), .rd_data(ram_pts.r_i)
   );

   // weights from the request position
   cpgi_weight u_weight (
      .clock(clock), .stage_en(stage_en),
      .k_row(ctl_ff[1].i), .d_row(ctl_ff[1].dm),
      .k_col(ctl_ff[1].j), .d_col(ctl_ff[1].dn),
      .weights(weights)
   );

   // blend of edges and corners
   cpgi_blend u_blend (
      .clock(clock), .stage_en(stage_en), .weights(weights),
      .pts(pts_ff), .result(blend_pt)
   );

   // stored point for a boundary query
   always_comb begin
      unique case (ctl_ff[6].sel)
         SEL_TOP:    bnd_in = ram_pts.t_j;
         SEL_BOTTOM: bnd_in = ram_pts.b_j;
         SEL_LEFT:   bnd_in = ram_pts.l_i;
         SEL_RIGHT:  bnd_in = ram_pts.r_i;
         default:    bnd_in = '0;
      endcase
   end

   // result select
   always_comb begin
      unique case (ctl_ff[9].sel)
         SEL_OUTSIDE: begin
            rsp_pt_in     = '0;
            rsp_status_in = 1'b1;
         end
         SEL_INTERIOR: begin
            rsp_pt_in     = blend_pt;
            rsp_status_in = 1'b0;
         end
         default: begin
            rsp_pt_in     = bnd_ff[9];
            rsp_status_in = 1'b0;
         end
      endcase
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         ctl_ff[1] <= ctl_in;
      end
      for (int k = 2; k <= 9; k++) begin
         if (stage_en[k]) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
      if (stage_en[7]) begin
         pts_ff    <= ram_pts;
         bnd_ff[7] <= bnd_in;
      end
      for (int k = 8; k <= 9; k++) begin
         if (stage_en[k]) begin
            bnd_ff[k] <= bnd_ff[k-1];
         end
      end
      if (stage_en[NUM_STAGES]) begin
         rsp_pt_ff     <= rsp_pt_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign req_tready   = stage_en[1];
   assign rsp_tvalid   = valid_ff[NUM_STAGES];
   assign rsp_tdata    = rsp_pt_ff;
   assign rsp_tuser[0] = rsp_status_ff;

   // loads never go past the store stage
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] |-> ctl_ff[6].is_query)
      else $error("load request reached the blend stages");

   // queries never write the boundary stores
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[5] && ctl_ff[5].is_query) |->
         !(ctl_ff[5].wr_top || ctl_ff[5].wr_bot || ctl_ff[5].wr_left || ctl_ff[5].wr_right))
      else $error("query request marked as store write");

   // an outside query answers all zeros
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("outside query with nonzero coordinates");

endmodule
